// ----- sv/sync_header_frame_receiver_top_defines.svh -----
// Assertion macros for the sync header frame receiver.
// Needs a signal named clock and a signal named reset in the including module.
`ifndef SYNC_HEADER_FRAME_RECEIVER_TOP_DEFINES_SVH
`define SYNC_HEADER_FRAME_RECEIVER_TOP_DEFINES_SVH

// ante implies cons in the same cycle
`define SHFR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// ante implies cons in the next cycle
`define SHFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/shfr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the sync header frame receiver.
// No dependencies.
package shfr_pkg;

   localparam logic [7:0] HEAD_BYTE = 8'hA5;
   localparam logic [7:0] SYNC_BYTE = 8'h5A;
   localparam logic [7:0] FAIL_CMD  = 8'hFF;

   localparam int BYTE_W = 8;
   localparam int IDX_W  = 6;
   localparam int LEN_W  = 7;
   localparam int RSP_W  = 32;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SUM  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

// ----- sv/shfr_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module shfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/sync_header_frame_receiver_top.sv -----
`timescale 1ns / 1ps
// Sync header frame receiver: stores received bytes, detects frame completion,
// checks the additive checksum and streams the frame out. Uses shfr_pkg, shfr_ram.
//
// Each received byte is written to a frame store; 0xA5 followed by 0x5A restarts the
// frame at index 0, and the write index sticks at the last entry once the store is
// full. A byte other than 0xA5 or 0x5A completes the frame when the advanced index
// equals stored byte 0 (the length). A byte that does not complete a frame leaves
// the block ready for the next byte. After a completing byte the block reads the
// frame once to form the checksum, then streams the frame out at one word per cycle
// when the output is not stalled, and req_tready returns once the final word is
// taken; the frame store has a single read port, so the frame is read twice.
// Every output word carries the length, the verdict, and the command byte (255 on
// a failed checksum or a frame shorter than 3 bytes).
`include "sync_header_frame_receiver_top_defines.svh"
module sync_header_frame_receiver_top
   import shfr_pkg::*;
#(
   parameter int STORE_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // [7:0] frame_byte, [13:8] byte_index,
                                         // [20:14] frame_length, [28:21] command,
                                         // [29] checksum_ok, [31:30] zero
   output logic             rsp_tlast    // last
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = AW + 1;

   state_type         state_ff, state_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic              head_ff, head_in;
   logic [BYTE_W-1:0] len0_ff, len0_in;
   logic [CW-1:0]     flen_ff, flen_in;
   logic [CW-1:0]     rd_addr_ff, rd_addr_in;
   logic              sv_ff, sv_in;
   logic [AW-1:0]     sidx_ff, sidx_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] chk_ff, chk_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic              ok_ff, ok_in;
   logic [BYTE_W-1:0] cmd_out_ff, cmd_out_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pidx_ff, pidx_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [BYTE_W-1:0] obyte_ff, obyte_in;
   logic [AW-1:0]     oidx_ff, oidx_in;
   logic              olast_ff, olast_in;

   logic              ram_we;
   logic              ram_re;
   logic [BYTE_W-1:0] ram_q;

   logic [BYTE_W-1:0] rx_byte;
   logic              is_head, is_sync, do_write, done;
   logic [CW-1:0]     idx_inc;
   logic [CW-1:0]     sx;
   logic              load, issue;

   assign rx_byte  = req_tdata[BYTE_W-1:0];
   assign is_head  = (rx_byte == HEAD_BYTE);
   assign is_sync  = (rx_byte == SYNC_BYTE);
   assign do_write = !(is_sync && head_ff);
   assign idx_inc  = CW'(idx_ff) + CW'(1);
   assign sx       = CW'(sidx_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign ram_we     = req_tvalid && req_tready && do_write;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      head_in       = head_ff;
      len0_in       = len0_ff;
      flen_in       = flen_ff;
      rd_addr_in    = rd_addr_ff;
      sv_in         = 1'b0;
      sidx_in       = sidx_ff;
      sum_in        = sum_ff;
      chk_in        = chk_ff;
      cmd_in        = cmd_ff;
      ok_in         = ok_ff;
      cmd_out_in    = cmd_out_ff;
      pend_in       = pend_ff;
      pidx_in       = pidx_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      obyte_in      = obyte_ff;
      oidx_in       = oidx_ff;
      olast_in      = olast_ff;
      ram_re        = 1'b0;
      done          = 1'b0;
      load          = 1'b0;
      issue         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               head_in = is_head;
               if (do_write && (idx_ff == '0)) begin
                  len0_in = rx_byte;
               end
               if (!do_write) begin
                  idx_in = '0;
               end else if (idx_inc == CW'(STORE_DEPTH)) begin
                  idx_in = AW'(STORE_DEPTH - 1);
               end else begin
                  idx_in = idx_inc[AW-1:0];
               end
               // compare against byte 0 as it stands after this write
               done = !is_head && !is_sync && (BYTE_W'(idx_inc) == len0_in);
               if (done) begin
                  flen_in    = idx_inc;
                  rd_addr_in = '0;
                  sum_in     = '0;
                  chk_in     = '0;
                  cmd_in     = '0;
                  state_in   = ST_SUM;
               end
            end
         end

         ST_SUM: begin
            issue = (rd_addr_ff < flen_ff);
            if (issue) begin
               ram_re     = 1'b1;
               sv_in      = 1'b1;
               sidx_in    = rd_addr_ff[AW-1:0];
               rd_addr_in = rd_addr_ff + CW'(1);
            end
            if (sv_ff) begin
               if (sx + CW'(2) < flen_ff) begin
                  sum_in = sum_ff + ram_q;
               end
               if (sx + CW'(2) == flen_ff) begin
                  chk_in = ram_q;
               end
               if (sx == CW'(1)) begin
                  cmd_in = ram_q;
               end
            end
            if (!issue && !sv_ff) begin
               ok_in      = (flen_ff >= CW'(3)) && (sum_ff == chk_ff);
               cmd_out_in = ok_in ? cmd_ff : FAIL_CMD;
               rd_addr_in = '0;
               pend_in    = 1'b0;
               state_in   = ST_EMIT;
            end
         end

         ST_EMIT: begin
            load  = pend_ff && (!rsp_tvalid_ff || rsp_tready);
            issue = (rd_addr_ff < flen_ff) && (!pend_ff || load);
            if (load) begin
               rsp_tvalid_in = 1'b1;
               obyte_in      = ram_q;
               oidx_in       = pidx_ff;
               olast_in      = (CW'(pidx_ff) + CW'(1) == flen_ff);
            end else if (rsp_tready) begin
               rsp_tvalid_in = 1'b0;
            end
            if (issue) begin
               ram_re     = 1'b1;
               pidx_in    = rd_addr_ff[AW-1:0];
               rd_addr_in = rd_addr_ff + CW'(1);
            end
            pend_in = issue || (pend_ff && !load);
            // leave once the final word is taken
            if (rsp_tvalid_ff && rsp_tready && olast_ff) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         head_ff       <= 1'b0;
         len0_ff       <= '0;
         rd_addr_ff    <= '0;
         sv_ff         <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         head_ff       <= head_in;
         len0_ff       <= len0_in;
         rd_addr_ff    <= rd_addr_in;
         sv_ff         <= sv_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      flen_ff    <= flen_in;
      sidx_ff    <= sidx_in;
      sum_ff     <= sum_in;
      chk_ff     <= chk_in;
      cmd_ff     <= cmd_in;
      ok_ff      <= ok_in;
      cmd_out_ff <= cmd_out_in;
      pidx_ff    <= pidx_in;
      obyte_ff   <= obyte_in;
      oidx_ff    <= oidx_in;
      olast_ff   <= olast_in;
   end

   shfr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (idx_ff),
      .wdata (rx_byte),
      .re    (ram_re),
      .raddr (rd_addr_ff[AW-1:0]),
      .rdata (ram_q)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {2'b00, ok_ff, cmd_out_ff, LEN_W'(flen_ff), IDX_W'(oidx_ff), obyte_ff};

   `SHFR_ASSERT_NOW(a_out_only_in_emit, rsp_tvalid_ff, state_ff == ST_EMIT,
      "output word outside emit phase")
   `SHFR_ASSERT_NOW(a_addr_in_frame, state_ff != ST_IDLE, rd_addr_ff <= flen_ff,
      "read address ran past frame length")
   `SHFR_ASSERT_NEXT(a_idle_after_last, rsp_tvalid_ff && rsp_tready && olast_ff,
      req_tready && !rsp_tvalid_ff && !pend_ff, "block not idle after final word")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for sync_header_frame_receiver_top: a directed byte table, then
// random frames, noise and cut-off frames, with every output word checked against a
// frame predictor. Uses shfr_pkg and the receiver RTL.
module tb_top
   import shfr_pkg::*;
();

   localparam int STORE_DEPTH   = 64;
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 450;
   localparam int STALL_LIMIT   = 5000;
   localparam int DRAIN_CYCLES  = 140;
   localparam int HOLD_OFF      = 400;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic [5:0] byte_index;
      logic       last;
      logic [6:0] frame_length;
      logic [7:0] command;
      logic       checksum_ok;
   } frame_word_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic [6:0] exp_length;   // 0: no typed expectation, use the predictor
      logic [7:0] exp_command;
      logic       exp_ok;
   } stim_row_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [7:0]       req_tdata;     // [7:0] rx_byte
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;     // [7:0] frame_byte, [13:8] byte_index,
                                    // [20:14] frame_length, [28:21] command,
                                    // [29] checksum_ok, [31:30] zero
   logic             rsp_tlast;     // last

   sync_header_frame_receiver_top #(.STORE_DEPTH(STORE_DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // predictor state
   logic [7:0]     shadow_store [STORE_DEPTH];
   int             shadow_idx  = 0;
   bit             shadow_head = 1'b0;
   frame_word_type frame_words_due [$];
   frame_word_type due_word;

   logic [7:0]   byte_plan [$];
   stim_row_type directed_rows [DIRECTED_ROWS];

   bit steady      = 1'b0;
   int hold_cycles = 0;
   int errors      = 0;
   int bytes_sent  = 0;
   int frames_due  = 0;
   int frames_bad  = 0;
   int longest     = 0;
   int words_checked = 0;
   int stall_cycles  = 0;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic predict_byte(input logic [7:0] rx, input logic [6:0] pin_len,
                               input logic [7:0] pin_cmd, input logic pin_ok);
      bit             done;
      bit             ok;
      int             len;
      int             k;
      logic [7:0]     sum;
      logic [7:0]     cmd;
      frame_word_type w;
      ok  = 1'b0;
      cmd = FAIL_CMD;
      len = 0;
      if (rx == SYNC_BYTE && shadow_head) begin
         shadow_idx = 0;
      end else begin
         shadow_store[shadow_idx] = rx;
         shadow_idx++;
      end
      // completion is tested before the index is pulled back
      done = rx != HEAD_BYTE && rx != SYNC_BYTE && shadow_idx == int'(shadow_store[0]);
      shadow_head = (rx == HEAD_BYTE);
      if (shadow_idx >= STORE_DEPTH) shadow_idx = STORE_DEPTH - 1;
      if (done) begin
         len = int'(shadow_store[0]);
         sum = 8'h00;
         for (k = 0; k < len - 2; k++) sum += shadow_store[k];
         ok  = (len >= 3) ? (sum == shadow_store[len - 2]) : 1'b0;
         cmd = ok ? shadow_store[1] : FAIL_CMD;
      end
      if (pin_len != 0) begin
         done = 1'b1;
         len  = int'(pin_len);
         cmd  = pin_cmd;
         ok   = pin_ok;
      end
      if (done) begin
         frames_due++;
         if (!ok) frames_bad++;
         if (len > longest) longest = len;
         for (k = 0; k < len; k++) begin
            w.frame_byte   = shadow_store[k];
            w.byte_index   = k[5:0];
            w.last         = (k == len - 1);
            w.frame_length = len[6:0];
            w.command      = cmd;
            w.checksum_ok  = ok;
            frame_words_due.push_back(w);
         end
      end
   endtask

   task automatic send_byte(input logic [7:0] rx, input logic [6:0] pin_len,
                            input logic [7:0] pin_cmd, input logic pin_ok);
      while (!steady && $urandom_range(99) < 29) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      predict_byte(rx, pin_len, pin_cmd, pin_ok);
   endtask

   task automatic pause_for_results();
      req_tvalid <= 1'b0;
      wait (frame_words_due.size() == 0);
      @(posedge clock);
   endtask

   function automatic logic [7:0] ordinary_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == HEAD_BYTE || b == SYNC_BYTE);
      return b;
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 8) return $urandom_range(2, 1);
      else if (r < 86) return $urandom_range(12, 3);
      else if (r < 97) return $urandom_range(40, 13);
      else return $urandom_range(STORE_DEPTH, 41);
   endfunction

   task automatic plan_frame(input int len, input bit good_sum);
      logic [7:0] body [STORE_DEPTH];
      logic [7:0] sum;
      int         k;
      byte_plan.push_back(HEAD_BYTE);
      if ($urandom_range(9) == 0) byte_plan.push_back(HEAD_BYTE);
      byte_plan.push_back(SYNC_BYTE);
      body[0] = len[7:0];
      for (k = 1; k < len; k++) body[k] = 8'($urandom_range(255));
      // the closing byte has to be ordinary or the frame never completes
      if (len > 1) body[len - 1] = ordinary_byte();
      if (len >= 3) begin
         sum = 8'h00;
         for (k = 0; k < len - 2; k++) sum += body[k];
         body[len - 2] = good_sum ? sum : sum ^ 8'($urandom_range(255, 1));
      end
      for (k = 0; k < len; k++) byte_plan.push_back(body[k]);
   endtask

   task automatic plan_noise();
      int n;
      int r;
      n = $urandom_range(6, 1);
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 20) byte_plan.push_back(HEAD_BYTE);
         else if (r < 40) byte_plan.push_back(SYNC_BYTE);
         else byte_plan.push_back(8'($urandom_range(255)));
      end
   endtask

   task automatic check_field(input string name, input int expv, input int actv);
      if (expv != actv) begin
         if (errors < 40)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
         errors++;
      end
   endtask

   // receiver: random stalls, one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 29);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (frame_words_due.size() == 0) begin
            if (errors < 40)
               $display("%0t ns: unexpected word, expected none, actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            due_word = frame_words_due.pop_front();
            check_field("frame_byte", int'(due_word.frame_byte), int'(rsp_tdata[7:0]));
            check_field("byte_index", int'(due_word.byte_index), int'(rsp_tdata[13:8]));
            check_field("frame_length", int'(due_word.frame_length),
                        int'(rsp_tdata[20:14]));
            check_field("command", int'(due_word.command), int'(rsp_tdata[28:21]));
            check_field("checksum_ok", int'(due_word.checksum_ok), int'(rsp_tdata[29]));
            check_field("last", int'(due_word.last), int'(rsp_tlast));
            words_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no word moved for %0d cycles, %0d words still due",
                  $time, STALL_LIMIT, frame_words_due.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int  kind;
      int  len;
      int  random_sent;
      int  pause_at;
      int  full_runs;
      bit  hold_done;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      random_sent = 0;
      pause_at    = 0;
      full_runs   = 0;
      hold_done   = 1'b0;
      directed_rows = '{
         // one-byte frame straight after reset
         '{8'hA5, 7'd0, 8'h00, 1'b0}, '{8'h5A, 7'd0, 8'h00, 1'b0},
         '{8'h01, 7'd1, FAIL_CMD, 1'b0},
         // two-byte frame: too short for a checksum
         '{8'hA5, 7'd0, 8'h00, 1'b0}, '{8'h5A, 7'd0, 8'h00, 1'b0},
         '{8'h02, 7'd0, 8'h00, 1'b0}, '{8'h07, 7'd2, FAIL_CMD, 1'b0},
         // good frame with command 0xFF and a wrapping sum, closed by 0x00
         '{8'hA5, 7'd0, 8'h00, 1'b0}, '{8'h5A, 7'd0, 8'h00, 1'b0},
         '{8'h04, 7'd0, 8'h00, 1'b0}, '{8'hFF, 7'd0, 8'h00, 1'b0},
         '{8'h03, 7'd0, 8'h00, 1'b0}, '{8'h00, 7'd4, 8'hFF, 1'b1},
         // repeated head, then a bad checksum
         '{8'hA5, 7'd0, 8'h00, 1'b0}, '{8'hA5, 7'd0, 8'h00, 1'b0},
         '{8'h5A, 7'd0, 8'h00, 1'b0}, '{8'h03, 7'd0, 8'h00, 1'b0},
         '{8'h10, 7'd0, 8'h00, 1'b0}, '{8'h77, 7'd3, FAIL_CMD, 1'b0},
         // sync byte with no head in front is stored
         '{8'h5A, 7'd0, 8'h00, 1'b0},
         // smallest frame that passes
         '{8'hA5, 7'd0, 8'h00, 1'b0}, '{8'h5A, 7'd0, 8'h00, 1'b0},
         '{8'h03, 7'd0, 8'h00, 1'b0}, '{8'h03, 7'd0, 8'h00, 1'b0},
         '{8'h80, 7'd3, 8'h03, 1'b1}
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_byte(directed_rows[i].rx_byte, directed_rows[i].exp_length,
                   directed_rows[i].exp_command, directed_rows[i].exp_ok);

      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent >= 60 && !hold_done) begin
            hold_cycles = HOLD_OFF;
            hold_done   = 1'b1;
         end
         steady = (random_sent >= 200 && random_sent < 300);
         if (random_sent >= pause_at) begin
            pause_for_results();
            pause_at += 150;
         end
         byte_plan.delete();
         kind = $urandom_range(99);
         if (kind < 68) begin
            plan_frame(pick_length(), $urandom_range(4) != 0);
         end else if (kind < 82) begin
            plan_noise();
         end else if (kind < 95) begin
            // cut a frame short and leave it for the next head to restart
            len = $urandom_range(12, 3);
            plan_frame(len, 1'b1);
            repeat ($urandom_range(len - 1, 1)) void'(byte_plan.pop_back());
         end else if (full_runs < 3) begin
            // full store: each extra ordinary byte lands on the last entry and completes again
            full_runs++;
            plan_frame(STORE_DEPTH, 1'b1);
            repeat ($urandom_range(2, 1)) byte_plan.push_back(ordinary_byte());
         end else begin
            plan_noise();
         end
         foreach (byte_plan[i]) send_byte(byte_plan[i], 7'd0, 8'h00, 1'b0);
         random_sent += byte_plan.size();
      end
      steady = 1'b0;

      pause_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run sent %0d bytes (%0d from the table) and checked %0d words of %0d frames,",
               bytes_sent, DIRECTED_ROWS, words_checked, frames_due);
      $display("%0d frames short or with a bad checksum, longest frame %0d bytes.",
               frames_bad, longest);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
